### rtl/bba_pkg.sv
// Package for the buddy block allocator: field widths, status and
// action codes, configuration register indexes and sequencer states.
// No dependencies.
package bba_pkg;

   localparam int MAX_LEVELS  = 10;
   localparam int REQ_BYTES_W = 25;
   localparam int NODE_W      = MAX_LEVELS;
   localparam int LEVEL_W     = 4;
   localparam int OFFSET_W    = 25;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int MIN_BLOCK_W = 16;
   localparam int HEADER_W    = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_NO_SPACE = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_BLOCK   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER      = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SIZE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SPLIT_TOP,
      ST_SPLIT_R,
      ST_SPLIT_L,
      ST_FREE_CHK,
      ST_FREE_RD,
      ST_FREE_EVAL,
      ST_MERGE_N,
      ST_MERGE_B,
      ST_MERGE_P,
      ST_MARK,
      ST_LEVEL,
      ST_OFFSET,
      ST_RESULT
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [NODE_W-1:0]         node_index;
      logic [LEVEL_W-1:0]        node_level;
      logic [OFFSET_W-1:0]       block_offset;
   } rsp_type;

endpackage

### rtl/bba_if.sv
// Valid/ready channel interface used by all block ports.
// Depends on nothing; payload type is a parameter.
interface bba_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/bba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One access per cycle; the read port returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### rtl/bba_shift_mul.sv
// Shared shift-and-add multiplier for block offsets, one bit per cycle.
// Depends on nothing; operand widths are parameters.
module bba_shift_mul #(
   parameter int A_W = 10,
   parameter int B_W = 25,
   parameter int P_W = 25
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] op_a,
   input  logic [B_W-1:0] op_b,
   output logic           busy,
   output logic [P_W-1:0] product
);
   logic [A_W-1:0] a_ff, a_in;
   logic [P_W-1:0] b_ff, b_in;
   logic [P_W-1:0] p_ff, p_in;
   logic           busy_ff, busy_in;

   // While busy, each cycle adds the shifted multiplicand when the low multiplier bit is set.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = op_a;
         b_in    = P_W'(op_b);
         p_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff[0]) begin
            p_in = p_ff + b_ff;
         end
         a_in = a_ff >> 1;
         b_in = b_ff << 1;
         if (a_ff[A_W-1:1] == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   assign busy    = busy_ff;
   assign product = p_ff;
endmodule

### rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: sequencer, free map RAM and
// offset multiplier. Depends on bba_pkg, bba_if, bba_ram and bba_shift_mul.
//
// Channel | Direction | Payload
// req_    | in        | action, request_bytes, block_index
// rsp_    | out       | status, node_index, node_level, block_offset
// csr_    | in        | csr index, csr data
//
// One transaction at a time. An allocate scans free map nodes, splits down
// to the wanted level and then runs the offset multiply; a free merges up
// level by level, finds the level and then runs the multiply. The single
// free map port serialises these steps.
// After reset, and after each level_count write, a clearing pass sweeps all
// 2^MAX_LEVELS map entries.
// The result waits in an output register; stalls hold it there.
module buddy_block_allocator (
   input logic clock,
   input logic reset,
   bba_if.sink   req_ch,
   bba_if.source rsp_ch,
   bba_if.sink   csr_ch
);
   import bba_pkg::*;

   localparam int AW = MAX_LEVELS;
   localparam int DEPTH = 1 << MAX_LEVELS;

   // Configuration registers.
   logic [LEVEL_W-1:0]     lc_ff;
   logic [MIN_BLOCK_W-1:0] minb_ff;
   logic [HEADER_W-1:0]    hdr_ff;

   state_type state_ff, state_in;

   logic [REQ_BYTES_W-1:0] reqb_ff;
   logic [AW-1:0]     node_ff, node_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in, want_ff, want_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [REQ_BYTES_W+1:0] size_ff, size_in;
   logic [LEVEL_W-1:0] up_ff, up_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              csr_clear;

   // RAM port.
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic          ram_wd, ram_rd;

   bba_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   // Offset multiplier.
   logic                mul_start, mul_busy;
   logic [AW-1:0]       mul_a;
   logic [OFFSET_W-1:0] mul_b, mul_p;

   bba_shift_mul #(.A_W(AW), .B_W(OFFSET_W), .P_W(OFFSET_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   // Level-dependent node bounds.
   logic [AW:0] first_of_lvl;
   assign first_of_lvl = (AW+1)'((AW+1)'(1) << lvl_ff) - (AW+1)'(1);

   // Block size for the returned level, truncated to the offset width.
   logic [LEVEL_W-1:0] size_shift;
   assign size_shift = lc_ff - LEVEL_W'(1) - lvl_ff;
   assign mul_a = AW'(node_ff - first_of_lvl[AW-1:0]);
   assign mul_b = OFFSET_W'({{(OFFSET_W-MIN_BLOCK_W){1'b0}}, minb_ff} << size_shift);

   logic [AW-1:0] buddy;
   assign buddy = node_ff[0] ? node_ff + AW'(1) : node_ff - AW'(1);

   assign csr_clear = csr_ch.valid && csr_ch.ready &&
                      (csr_ch.payload.addr == CSR_LEVEL_COUNT);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff   <= LEVEL_W'(MAX_LEVELS);
         minb_ff <= MIN_BLOCK_W'(16);
         hdr_ff  <= HEADER_W'(4);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.payload.addr)
            CSR_LEVEL_COUNT: begin
               if (csr_ch.payload.data[LEVEL_W-1:0] == '0) begin
                  lc_ff <= LEVEL_W'(1);
               end else if (csr_ch.payload.data[LEVEL_W-1:0] > LEVEL_W'(MAX_LEVELS)) begin
                  lc_ff <= LEVEL_W'(MAX_LEVELS);
               end else begin
                  lc_ff <= csr_ch.payload.data[LEVEL_W-1:0];
               end
            end
            CSR_MIN_BLOCK: begin
               minb_ff <= (csr_ch.payload.data == '0) ? MIN_BLOCK_W'(1)
                                                       : csr_ch.payload.data;
            end
            CSR_HEADER: hdr_ff <= csr_ch.payload.data[HEADER_W-1:0];
            default: ;
         endcase
      end
   end

   // A register write takes priority over a request in the same cycle.
   assign csr_ch.ready = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
   assign req_ch.ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !csr_ch.valid;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   logic [REQ_BYTES_W+1:0] total;
   assign total = (REQ_BYTES_W+2)'(reqb_ff) + (REQ_BYTES_W+2)'(hdr_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               state_in = (req_ch.payload.action == ACTION_FREE) ? ST_FREE_CHK : ST_SIZE;
            end
         end
         ST_CLEAR: if (node_ff == AW'(DEPTH-1)) state_in = ST_IDLE;
         ST_SIZE: begin
            if (reqb_ff == '0) state_in = ST_RESULT;
            else if (size_ff >= total) state_in = ST_SCAN_RD;
            else if (up_ff + LEVEL_W'(1) >= lc_ff) state_in = ST_RESULT;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (ram_rd) state_in = ST_SPLIT_TOP;
            else if (node_ff != last_ff) state_in = ST_SCAN_RD;
            else if (lvl_ff == '0) state_in = ST_RESULT;
            else state_in = ST_SCAN_RD;
         end
         ST_SPLIT_TOP: state_in = (lvl_ff == want_ff) ? ST_OFFSET : ST_SPLIT_R;
         ST_SPLIT_R: state_in = ST_SPLIT_L;
         ST_SPLIT_L: state_in = (lvl_ff + LEVEL_W'(1) == want_ff) ? ST_OFFSET : ST_SPLIT_R;
         ST_FREE_CHK: begin
            if ({1'b0, node_ff} >= (AW+1)'(((AW+1)'(1) << lc_ff) - (AW+1)'(1)))
               state_in = ST_RESULT;
            else if (node_ff == '0) state_in = ST_MARK;
            else state_in = ST_FREE_RD;
         end
         ST_FREE_RD: state_in = ST_FREE_EVAL;
         ST_FREE_EVAL: state_in = ram_rd ? ST_MERGE_N : ST_MARK;
         ST_MERGE_N: state_in = ST_MERGE_B;
         ST_MERGE_B: state_in = ST_MERGE_P;
         ST_MERGE_P: state_in = ST_FREE_CHK;
         ST_MARK: state_in = ST_LEVEL;
         ST_LEVEL: begin
            if ({1'b0, node_ff} + (AW+1)'(1) < ((AW+1)'(2) << lvl_ff) ||
                lvl_ff == LEVEL_W'(MAX_LEVELS-1))
               state_in = ST_OFFSET;
         end
         ST_OFFSET: if (!mul_start && !mul_busy) state_in = ST_RESULT;
         ST_RESULT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (csr_clear) state_in = ST_CLEAR;
   end

   logic mul_go_ff;

   // Datapath and outputs.
   always_comb begin
      node_in = node_ff;
      lvl_in = lvl_ff;
      want_in = want_ff;
      last_in = last_ff;
      size_in = size_ff;
      up_in = up_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;
      ram_addr = node_ff;
      ram_wd = 1'b0;
      mul_start = 1'b0;
      if (rsp_ch.valid && rsp_ch.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            node_in = AW'(req_ch.payload.block_index);
            size_in = (REQ_BYTES_W+2)'(minb_ff);
            up_in = '0;
            if (req_ch.valid && req_ch.ready) rsp_in = '0;
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wd = (node_ff == '0);
            node_in = node_ff + AW'(1);
         end
         ST_SIZE: begin
            if (reqb_ff == '0) begin
               rsp_in.status = STATUS_BAD_SIZE;
            end else if (size_ff >= total) begin
               want_in = lc_ff - LEVEL_W'(1) - up_ff;
               lvl_in = lc_ff - LEVEL_W'(1) - up_ff;
               node_in = AW'((AW+1)'(1) << (lc_ff - LEVEL_W'(1) - up_ff)) - AW'(1);
               last_in = AW'((AW+1)'(2) << (lc_ff - LEVEL_W'(1) - up_ff)) - AW'(2);
            end else begin
               size_in = size_ff << 1;
               up_in = up_ff + LEVEL_W'(1);
               if (up_ff + LEVEL_W'(1) >= lc_ff) rsp_in.status = STATUS_BAD_SIZE;
            end
         end
         ST_SCAN_RD: ;
         ST_SCAN_CHK: begin
            if (!ram_rd) begin
               if (node_ff != last_ff) begin
                  node_in = node_ff + AW'(1);
               end else if (lvl_ff == '0) begin
                  rsp_in.status = STATUS_NO_SPACE;
               end else begin
                  lvl_in = lvl_ff - LEVEL_W'(1);
                  node_in = AW'((AW+1)'(1) << (lvl_ff - LEVEL_W'(1))) - AW'(1);
                  last_in = AW'((AW+1)'(2) << (lvl_ff - LEVEL_W'(1))) - AW'(2);
               end
            end
         end
         ST_SPLIT_TOP: begin
            ram_we = 1'b1;
            ram_wd = 1'b0;
         end
         ST_SPLIT_R: begin
            ram_we = 1'b1;
            ram_wd = 1'b1;
            ram_addr = AW'({node_ff, 1'b0} + 2);
         end
         ST_SPLIT_L: begin
            ram_we = 1'b1;
            ram_wd = 1'b0;
            ram_addr = AW'({node_ff, 1'b0} + 1);
            node_in = AW'({node_ff, 1'b0} + 1);
            lvl_in = lvl_ff + LEVEL_W'(1);
         end
         ST_FREE_CHK: begin
            lvl_in = '0;
            if ({1'b0, node_ff} >= (AW+1)'(((AW+1)'(1) << lc_ff) - (AW+1)'(1)))
               rsp_in.status = STATUS_BAD_INDEX;
         end
         ST_FREE_RD: ram_addr = buddy;
         ST_FREE_EVAL: ;
         ST_MERGE_N: begin
            ram_we = 1'b1;
         end
         ST_MERGE_B: begin
            ram_we = 1'b1;
            ram_addr = buddy;
         end
         ST_MERGE_P: begin
            node_in = (node_ff - AW'(1)) >> 1;
            ram_we = 1'b1;
            ram_wd = 1'b1;
            ram_addr = (node_ff - AW'(1)) >> 1;
         end
         ST_MARK: begin
            ram_we = 1'b1;
            ram_wd = 1'b1;
         end
         ST_LEVEL: begin
            if (!({1'b0, node_ff} + (AW+1)'(1) < ((AW+1)'(2) << lvl_ff) ||
                  lvl_ff == LEVEL_W'(MAX_LEVELS-1)))
               lvl_in = lvl_ff + LEVEL_W'(1);
         end
         ST_OFFSET: begin
            mul_start = !mul_go_ff;
            rsp_in.status = STATUS_OK;
            rsp_in.node_index = NODE_W'(node_ff);
            rsp_in.node_level = lvl_ff;
            rsp_in.block_offset = mul_p;
         end
         ST_RESULT: rsp_valid_in = 1'b1;
         default: ;
      endcase
      if (csr_clear) node_in = '0;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         node_ff <= '0;
         mul_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         node_ff <= node_in;
         mul_go_ff <= (state_ff == ST_OFFSET);
      end
      if (req_ch.valid && req_ch.ready) begin
         reqb_ff <= req_ch.payload.request_bytes;
      end
      lvl_ff <= lvl_in;
      want_ff <= want_in;
      last_ff <= last_in;
      size_ff <= size_in;
      up_ff <= up_in;
      rsp_ff <= rsp_in;
   end
endmodule

### tb/buddy_block_allocator_test.sv
// Self-checking testbench for buddy_block_allocator: directed table, then random
// allocate/free traffic over several register settings, checked by a local predictor.
// Depends on bba_pkg, bba_if and the allocator RTL.
module buddy_block_allocator_test;
   import bba_pkg::*;

   typedef struct packed {
      logic                   action;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [NODE_W-1:0]      block_index;
   } alloc_req_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct {
      logic        action;
      int unsigned bytes;
      int unsigned node;
      bit          typed;
      rsp_type     result;
   } table_row_type;

   localparam int NODE_COUNT = 1023;
   localparam longint unsigned CYCLE_LIMIT = 8_000_000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bba_if #(.payload_type(alloc_req_type)) req_if ();
   bba_if #(.payload_type(rsp_type))       rsp_if ();
   bba_if #(.payload_type(csr_write_type)) csr_if ();

   buddy_block_allocator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #1 clock = ~clock;

   // Predictor state: free map and register copies.
   logic        free_map [0:NODE_COUNT-1];
   int unsigned tree_levels;
   int unsigned min_block;
   int unsigned header_size;

   rsp_type       expected_results [$];
   bit            typed_flags [$];
   rsp_type       typed_results [$];
   int unsigned   live_nodes [$];
   int unsigned   error_count = 0;
   int unsigned   result_count = 0;
   int unsigned   ok_allocs = 0;
   int unsigned   merges = 0;
   bit            quiet = 1'b0;
   longint unsigned cycle_count = 0;

   function automatic void clear_free_map();
      for (int i = 0; i < NODE_COUNT; i++) free_map[i] = 1'b0;
      free_map[0] = 1'b1;
   endfunction

   function automatic logic [OFFSET_W-1:0] offset_of(int unsigned node, int unsigned lvl);
      longint unsigned first;
      longint unsigned size;
      first = (64'd1 << lvl) - 1;
      size  = longint'(min_block) << (tree_levels - 1 - lvl);
      return OFFSET_W'((longint'(node) - first) * size);
   endfunction

   function automatic rsp_type error_result(status_type code);
      rsp_type r;
      r = '0;
      r.status = code;
      return r;
   endfunction

   function automatic rsp_type predict_alloc(int unsigned bytes);
      longint unsigned total;
      longint unsigned size;
      int unsigned up;
      int unsigned want;
      int unsigned lvl;
      int unsigned node;
      bit found;
      rsp_type r;
      up = 0;
      found = 0;
      node = 0;
      if (bytes == 0) return error_result(STATUS_BAD_SIZE);
      total = longint'(bytes) + header_size;
      size = min_block;
      while (size < total) begin
         size = size << 1;
         up++;
         if (up >= tree_levels) return error_result(STATUS_BAD_SIZE);
      end
      want = tree_levels - 1 - up;
      // Search the wanted level first, then each level above it.
      lvl = want;
      forever begin
         for (int unsigned n = (1 << lvl) - 1; n < (2 << lvl) - 1; n++) begin
            if (free_map[n]) begin
               node = n;
               found = 1;
               break;
            end
         end
         if (found || lvl == 0) break;
         lvl--;
      end
      if (!found) return error_result(STATUS_NO_SPACE);
      // Split down the left side, freeing every right child.
      free_map[node] = 1'b0;
      while (lvl < want) begin
         free_map[2 * node + 2] = 1'b1;
         free_map[2 * node + 1] = 1'b0;
         node = 2 * node + 1;
         lvl++;
      end
      r.status = STATUS_OK;
      r.node_index = NODE_W'(node);
      r.node_level = LEVEL_W'(want);
      r.block_offset = offset_of(node, want);
      live_nodes.push_back(node);
      ok_allocs++;
      return r;
   endfunction

   function automatic rsp_type predict_free(int unsigned node);
      int unsigned buddy;
      int unsigned lvl;
      rsp_type r;
      if (node >= (1 << tree_levels) - 1) return error_result(STATUS_BAD_INDEX);
      forever begin
         if (node == 0) begin
            free_map[0] = 1'b1;
            break;
         end
         buddy = (node & 1) ? node + 1 : node - 1;
         if (!free_map[buddy]) begin
            free_map[node] = 1'b1;
            break;
         end
         free_map[node] = 1'b0;
         free_map[buddy] = 1'b0;
         node = (node - 1) / 2;
         free_map[node] = 1'b1;
         merges++;
      end
      lvl = 0;
      while (node + 1 >= (2 << lvl)) lvl++;
      r.status = STATUS_OK;
      r.node_index = NODE_W'(node);
      r.node_level = LEVEL_W'(lvl);
      r.block_offset = offset_of(node, lvl);
      return r;
   endfunction

   function automatic void apply_register(logic [CSR_ADDR_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_LEVEL_COUNT: begin
            tree_levels = data[3:0];
            if (tree_levels < 1) tree_levels = 1;
            if (tree_levels > 10) tree_levels = 10;
            clear_free_map();
            live_nodes.delete();
         end
         CSR_MIN_BLOCK: begin
            min_block = data;
            if (min_block == 0) min_block = 1;
         end
         CSR_HEADER: header_size = data[HEADER_W-1:0];
         default: ;
      endcase
   endfunction

   // Predict on every accepted request transaction and apply every accepted register write.
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && req_if.valid && req_if.ready) begin
         if (req_if.payload.action == ACTION_ALLOC)
            r = predict_alloc(req_if.payload.request_bytes);
         else
            r = predict_free(req_if.payload.block_index);
         if (typed_flags.pop_front()) r = typed_results.pop_front();
         expected_results.push_back(r);
      end
      if (!reset && csr_if.valid && csr_if.ready)
         apply_register(csr_if.payload.addr, csr_if.payload.data);
   end

   // Compare every result transaction with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         result_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d node %0d", got.status, got.node_index);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               error_count++;
            end
            if (got.node_index !== want.node_index) begin
               $error("node_index: expected %0d, got %0d", want.node_index, got.node_index);
               error_count++;
            end
            if (got.node_level !== want.node_level) begin
               $error("node_level: expected %0d, got %0d", want.node_level, got.node_level);
               error_count++;
            end
            if (got.block_offset !== want.block_offset) begin
               $error("block_offset: expected %0d, got %0d",
                      want.block_offset, got.block_offset);
               error_count++;
            end
         end
      end
   end

   // Result side stalls in random bursts until the quiet tail.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Send one request transaction; called at a falling edge.
   task automatic send_request(logic action, int unsigned bytes, int unsigned node,
                               bit typed, rsp_type result);
      alloc_req_type item;
      item.action = action;
      item.request_bytes = REQ_BYTES_W'(bytes);
      item.block_index = NODE_W'(node);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      typed_flags.push_back(typed);
      if (typed) typed_results.push_back(result);
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Wait for all results, then write one register.
   task automatic write_register(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload <= {index, data};
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_random_request();
      int unsigned pick;
      int unsigned node;
      int unsigned bytes;
      pick = $urandom_range(0, 99);
      if (live_nodes.size() != 0 && pick < 45) begin
         pick = $urandom_range(0, live_nodes.size() - 1);
         node = live_nodes[pick];
         live_nodes.delete(pick);
         send_request(ACTION_FREE, 0, node, 1'b0, '0);
      end else if (pick < 52) begin
         send_request(ACTION_FREE, $urandom, $urandom_range(0, 1023), 1'b0, '0);
      end else if (pick < 58) begin
         send_request(ACTION_ALLOC, $urandom_range(0, 33554431), $urandom, 1'b0, '0);
      end else begin
         bytes = min_block << $urandom_range(0, tree_levels - 1);
         bytes = $urandom_range(1, bytes);
         send_request(ACTION_ALLOC, bytes, $urandom, 1'b0, '0);
      end
   endtask

   table_row_type directed [$];

   function automatic table_row_type row(logic action, int unsigned bytes, int unsigned node,
                                         bit typed, status_type code, int unsigned n_index,
                                         int unsigned n_level, int unsigned offset);
      table_row_type t;
      t.action = action;
      t.bytes = bytes;
      t.node = node;
      t.typed = typed;
      t.result.status = code;
      t.result.node_index = NODE_W'(n_index);
      t.result.node_level = LEVEL_W'(n_level);
      t.result.block_offset = OFFSET_W'(offset);
      return t;
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      tree_levels = 10;
      min_block = 16;
      header_size = 4;
      clear_free_map();

      // Directed rows at the reset settings; typed results where obvious.
      directed.push_back(row(ACTION_ALLOC, 0, 0, 1, STATUS_BAD_SIZE, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 33554431, 1023, 1, STATUS_BAD_SIZE, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 8189, 0, 1, STATUS_BAD_SIZE, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 1023, 1, STATUS_BAD_INDEX, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 12, 0, 1, STATUS_OK, 511, 9, 0));
      directed.push_back(row(ACTION_ALLOC, 1, 0, 1, STATUS_OK, 512, 9, 16));
      directed.push_back(row(ACTION_ALLOC, 100, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 4000, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 2000, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 511, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 512, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 7, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 8188, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_ALLOC, 1, 0, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 1022, 0, STATUS_OK, 0, 0, 0));
      directed.push_back(row(ACTION_FREE, 0, 0, 0, STATUS_OK, 0, 0, 0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i].action, directed[i].bytes, directed[i].node,
                      directed[i].typed, directed[i].result);
      live_nodes.delete();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_MIN_BLOCK, 1);
               write_register(CSR_HEADER, 0);
               write_register(CSR_LEVEL_COUNT, 1);
            end
            1: begin
               write_register(CSR_MIN_BLOCK, 16'hFFFF);
               write_register(CSR_HEADER, 16);
               write_register(CSR_LEVEL_COUNT, 16'hFFFF);
            end
            2: begin
               write_register(CSR_MIN_BLOCK, 0);
               write_register(CSR_HEADER, 31);
               write_register(CSR_LEVEL_COUNT, 0);
            end
            3: begin
               write_register(CSR_MIN_BLOCK, 3);
               write_register(CSR_HEADER, 7);
               write_register(CSR_LEVEL_COUNT, 4);
            end
            4: begin
               write_register(CSR_MIN_BLOCK, 16'h5555);
               write_register(CSR_HEADER, 10);
               write_register(CSR_LEVEL_COUNT, 10);
            end
            default: begin
               write_register(CSR_MIN_BLOCK, 16);
               write_register(CSR_HEADER, 4);
               write_register(CSR_LEVEL_COUNT, 7);
               quiet = 1'b1;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_request();
      end
      req_if.valid <= 1'b0;

      while (expected_results.size() != 0) @(negedge clock);
      repeat (64) @(negedge clock);

      $display("Checked %0d results over %0d register settings.",
               result_count, RANDOM_PHASES + 1);
      $display("Successful allocations: %0d, buddy merges: %0d.", ok_allocs, merges);
      if (error_count == 0 && expected_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

### buddy_block_allocator.f
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ram.sv
rtl/bba_shift_mul.sv
rtl/buddy_block_allocator.sv
tb/buddy_block_allocator_test.sv
